// File: sv/indexed_list_store_top_defines.svh
// assertion macros for the indexed list store
// used by indexed_list_store_top; no other dependencies
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ILS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("indexed list store: same-cycle check failed");

// next-cycle implication, checked outside reset
`define ILS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("indexed list store: next-cycle check failed");

`endif

// File: sv/ils_pkg.sv
// shared types and codes for the indexed list store
// no dependencies
`default_nettype none

package ils_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int POS_W     = 8;
    localparam int WORD_W    = 32;
    localparam int CNT_OUT_W = 7;

    localparam logic [1:0] K_APPEND = 2'd0;
    localparam logic [1:0] K_INSERT = 2'd1;
    localparam logic [1:0] K_POP    = 2'd2;
    localparam logic [1:0] K_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [1:0]               status;
        logic [CNT_OUT_W-1:0]     count_after;
    } t_rsp;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: sv/ils_cell.sv
// one entry of the list: holds a word, takes it from a neighbor on shifts
// depends on ils_pkg
`default_nettype none

module ils_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 6
) (
    input  wire logic                              i_clk,
    input  wire ils_pkg::t_cell_cmd                i_cmd,
    input  wire logic [IW-1:0]                     i_idx,
    input  wire logic signed [ils_pkg::WORD_W-1:0] i_value,
    input  wire logic signed [ils_pkg::WORD_W-1:0] i_left,
    input  wire logic signed [ils_pkg::WORD_W-1:0] i_right,
    output logic signed [ils_pkg::WORD_W-1:0]      o_data,
    output logic signed [ils_pkg::WORD_W-1:0]      o_hit_data
);
    import ils_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [WORD_W-1:0] r_data;
    logic signed [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_IDX == i_idx) begin
                n_data = i_value;
            end else if (MY_IDX > i_idx) begin
                n_data = i_left;
            end
        end else if (i_cmd.pop && (MY_IDX >= i_idx)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    // masked word for the or-reduced read bus
    assign o_hit_data = (MY_IDX == i_idx) ? r_data : '0;

endmodule

`default_nettype wire

// File: sv/ils_mod.sv
// restoring remainder unit: position mod count, one position bit per cycle
// depends on ils_pkg
`default_nettype none

module ils_mod #(
    parameter int CW = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ils_pkg::POS_W-1:0] i_num,
    input  wire logic [CW-1:0]             i_den,
    output logic                           o_done,
    output logic [CW-1:0]                  o_rem
);
    import ils_pkg::*;

    localparam int SW = $clog2(POS_W);
    localparam logic [SW-1:0] LAST_STEP = SW'(POS_W - 1);

    logic            r_busy;
    logic            r_done;
    logic [SW-1:0]   r_step;
    logic [POS_W-1:0] r_num;
    logic [CW-1:0]   r_rem;
    logic [CW:0]     n_trial;
    logic [CW-1:0]   n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[POS_W-1]};
        if (n_trial >= {1'b0, i_den}) begin
            n_rem = CW'(n_trial - {1'b0, i_den});
        end else begin
            n_rem = n_trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[POS_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: sv/indexed_list_store_top.sv
// indexed list store: controller, remainder unit and a chain of entry cells
// depends on ils_pkg, ils_cell, ils_mod and indexed_list_store_top_defines.svh
//
//   channel   | handshake            | beat
//   request   | start, busy          | i_req  (kind, value, position)
//   result    | o_strobe, one cycle  | o_rsp  (word_out, status, count_after)
//
// append, and any request on an empty list: accept moves the state to exec, and the
// strobe register follows; insert, pop and peek on a non-empty list first wait in the
// remainder state for the bit-serial remainder unit that reduces position modulo count
// busy drops in the strobe cycle, so a new request may start then
// synchronous active-low reset empties the list; entries are not cleared
// results cannot be stalled: each strobe lasts one cycle
`default_nettype none
`include "indexed_list_store_top_defines.svh"

module indexed_list_store_top #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire ils_pkg::t_req i_req,
    output logic              o_strobe,
    output ils_pkg::t_rsp     o_rsp
);
    import ils_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_strobe;
    t_req          r_req;
    t_rsp          r_rsp;
    t_rsp          n_rsp;
    logic [IW-1:0] r_idx;

    logic          accept;
    logic          mod_start;
    logic          mod_done;
    logic [CW-1:0] mod_rem;
    logic          is_add;
    logic [1:0]    exec_status;
    t_cell_cmd     cell_cmd;

    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] cell_hit  [DEPTH];
    logic signed [WORD_W-1:0] rd_word;

    assign accept    = start && (r_state == S_IDLE);
    assign mod_start = accept && (i_req.kind != K_APPEND) && (r_count != '0);

    ils_mod #(
        .CW(CW)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_num  (i_req.position),
        .i_den  (r_count),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    // status and cell command for the request being executed
    always_comb begin
        is_add = (r_req.kind == K_APPEND) || (r_req.kind == K_INSERT);
        if (is_add && (r_count == FULL_CNT)) begin
            exec_status = ST_FULL;
        end else if (!is_add && (r_count == '0)) begin
            exec_status = ST_EMPTY;
        end else begin
            exec_status = ST_OK;
        end
        cell_cmd.ins = (r_state == S_EXEC) && is_add && (exec_status == ST_OK);
        cell_cmd.pop = (r_state == S_EXEC) && (r_req.kind == K_POP)
                       && (exec_status == ST_OK);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = r_req.value;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end
        ils_cell #(
            .INDEX(g),
            .IW   (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cell_cmd),
            .i_idx     (r_idx),
            .i_value   (r_req.value),
            .i_left    (left_w),
            .i_right   (right_w),
            .o_data    (cell_data[g]),
            .o_hit_data(cell_hit[g])
        );
    end

    // read bus: only the cell at r_idx passes its word; all others drive zero
    always_comb begin
        rd_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_word = rd_word | cell_hit[k];
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_rsp.word_out = '0;
        n_rsp.status   = exec_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = mod_start ? S_MOD : S_EXEC;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (cell_cmd.ins) begin
                    n_count = r_count + 1'b1;
                end else if (cell_cmd.pop) begin
                    n_count = r_count - 1'b1;
                end
                if (!is_add && (exec_status == ST_OK)) begin
                    n_rsp.word_out = rd_word;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp.count_after = CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            // append targets the slot past the end; empty list uses slot 0
            if (i_req.kind == K_APPEND) begin
                r_idx <= r_count[IW-1:0];
            end else begin
                r_idx <= '0;
            end
        end else if ((r_state == S_MOD) && mod_done) begin
            r_idx <= mod_rem[IW-1:0];
        end
        if (r_state == S_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `ILS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `ILS_ASSERT_NXT(a_exec_strobe, i_clk, i_rst_n, r_state == S_EXEC, r_strobe)
    `ILS_ASSERT_IMP(a_word_zero, i_clk, i_rst_n, r_strobe && (r_rsp.status != ST_OK), r_rsp.word_out == '0)
    `ILS_ASSERT_IMP(a_done_in_mod, i_clk, i_rst_n, mod_done, r_state == S_MOD)
    `ILS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy)

endmodule

`default_nettype wire

// File: test/indexed_list_store_top_tb.sv
// testbench for indexed_list_store_top: directed and random list requests,
// each result checked against an in-bench list model
// depends on ils_pkg and the indexed_list_store_top rtl
module indexed_list_store_top_tb;
    import ils_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int STALL_LIMIT = 300;
    localparam int TAIL_CYCLES = 16;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    // list model
    logic signed [WORD_W-1:0] list_words [LIST_DEPTH+1];
    int unsigned list_len = 0;

    t_rsp awaited_rsp [$];
    t_rsp want;

    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;
    int peak_len = 0;
    int stall_cycles = 0;

    indexed_list_store_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // applies one request to the list model and returns the result it gives
    function automatic t_rsp apply_list_req(input t_req r);
        t_rsp o;
        int unsigned slot;
        int unsigned k;
        o = '0;
        o.status = ST_OK;
        slot = 0;
        if (r.kind == K_APPEND || r.kind == K_INSERT) begin
            if (list_len >= LIST_DEPTH) begin
                o.status = ST_FULL;
            end else if (r.kind == K_APPEND) begin
                list_words[list_len] = r.value;
                list_len++;
            end else begin
                // empty list: word lands at slot 0
                if (list_len != 0) slot = r.position % list_len;
                for (k = list_len; k > slot; k--) list_words[k] = list_words[k-1];
                list_words[slot] = r.value;
                list_len++;
            end
        end else begin
            if (list_len == 0) begin
                o.status = ST_EMPTY;
            end else begin
                slot = r.position % list_len;
                o.word_out = list_words[slot];
                if (r.kind == K_POP) begin
                    list_len--;
                    for (k = slot; k < list_len; k++) list_words[k] = list_words[k+1];
                end
            end
        end
        o.count_after = list_len[CNT_OUT_W-1:0];
        if (o.status == ST_FULL) n_full++;
        if (o.status == ST_EMPTY) n_empty++;
        if (list_len > peak_len) peak_len = list_len;
        return o;
    endfunction

    function automatic t_req make_rand_req(input bit grow);
        t_req r;
        int roll;
        roll = $urandom_range(0, 9);
        if (grow)
            r.kind = (roll < 4) ? K_APPEND : (roll < 7) ? K_INSERT :
                     (roll < 8) ? K_POP : K_PEEK;
        else
            r.kind = (roll < 1) ? K_APPEND : (roll < 2) ? K_INSERT :
                     (roll < 7) ? K_POP : K_PEEK;
        case ($urandom_range(0, 7))
            0:       r.value = 32'sh7FFF_FFFF;
            1:       r.value = 32'sh8000_0000;
            2:       r.value = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: r.value = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       r.position = 8'd255;
            1:       r.position = 8'd0;
            2, 3, 4: r.position = (list_len > 1) ?
                                  POS_W'($urandom_range(0, list_len - 1)) : 8'd0;
            default: r.position = POS_W'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    // drives one beat and waits until the block takes it
    task automatic send_req(input t_req r, input int gap_pct);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        awaited_rsp.push_back(apply_list_req(r));
        n_sent++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic signed [WORD_W-1:0] value,
                               input logic [POS_W-1:0] position);
        t_req r;
        r.kind = kind;
        r.value = value;
        r.position = position;
        send_req(r, 30);
    endtask

    // random mix that swings the list between empty and full
    task automatic walk_list(input int n_items, input bit with_gaps);
        t_req r;
        bit grow;
        int gap_pct;
        int k;
        grow = 1'b1;
        gap_pct = 0;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0)
                gap_pct = with_gaps ? 25 * $urandom_range(0, 2) : 0;
            if (list_len >= LIST_DEPTH && $urandom_range(0, 2) == 0) grow = 1'b0;
            if (list_len == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
            if ($urandom_range(0, 99) == 0) grow = !grow;
            r = make_rand_req(grow);
            send_req(r, gap_pct);
        end
    endtask

    task automatic test_empty_list();
        send_fields(K_POP, 32'sd0, 8'd0);
        send_fields(K_PEEK, 32'sd0, 8'd255);
        send_fields(K_INSERT, 32'sd5, 8'd200);
        send_fields(K_PEEK, 32'sd0, 8'd37);
        send_fields(K_POP, 32'sd0, 8'd255);
        send_fields(K_PEEK, -32'sd1, 8'd1);
    endtask

    task automatic test_field_extremes();
        send_fields(K_APPEND, 32'sh7FFF_FFFF, 8'd0);
        send_fields(K_APPEND, 32'sh8000_0000, 8'd255);
        send_fields(K_APPEND, 32'sd0, 8'd0);
        send_fields(K_APPEND, -32'sd1, 8'd128);
        send_fields(K_INSERT, 32'sh5555_5555, 8'd255);
        send_fields(K_INSERT, 32'shAAAA_AAAA, 8'd0);
        send_fields(K_PEEK, 32'sd0, 8'd0);
        send_fields(K_PEEK, 32'sd0, 8'd255);
        send_fields(K_PEEK, 32'sd0, 8'd5);
        send_fields(K_POP, 32'sd0, 8'd128);
        send_fields(K_POP, 32'sd0, 8'd1);
        send_fields(K_POP, 32'sd0, 8'd255);
        send_fields(K_POP, 32'sd0, 8'd0);
    endtask

    task automatic test_full_list();
        t_req r;
        while (list_len < LIST_DEPTH) begin
            r = make_rand_req(1'b1);
            r.kind = $urandom_range(0, 1) ? K_APPEND : K_INSERT;
            send_req(r, 25);
        end
        send_fields(K_APPEND, 32'sh1234_5678, 8'd0);
        send_fields(K_INSERT, -32'sd7, 8'd255);
        send_fields(K_PEEK, 32'sd0, 8'd255);
        send_fields(K_PEEK, 32'sd0, 8'd63);
        send_fields(K_POP, 32'sd0, 8'd255);
        send_fields(K_INSERT, 32'sd99, 8'd255);
        send_fields(K_POP, 32'sd0, 8'd64);
        while (list_len > 0) begin
            r = make_rand_req(1'b0);
            r.kind = K_POP;
            send_req(r, 25);
        end
        send_fields(K_POP, 32'sd3, 8'd255);
    endtask

    task automatic test_random_mix();
        walk_list(1030, 1'b1);
    endtask

    task automatic test_back_to_back();
        walk_list(150, 1'b0);
    endtask

    // one result beat per strobe; compare against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (awaited_rsp.size() == 0) begin
                $error("result beat with nothing expected: word_out %0d status %0d count %0d",
                       o_rsp.word_out, o_rsp.status, o_rsp.count_after);
                n_errors++;
            end else begin
                want = awaited_rsp.pop_front();
                n_checked++;
                if (o_rsp.word_out !== want.word_out) begin
                    $error("word_out: expected %0d, actual %0d", want.word_out, o_rsp.word_out);
                    n_errors++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.count_after !== want.count_after) begin
                    $error("count_after: expected %0d, actual %0d",
                           want.count_after, o_rsp.count_after);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_field_extremes();
        test_full_list();
        test_random_mix();
        test_back_to_back();

        start <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results; %0d full and %0d empty outcomes,",
                 n_sent, n_checked, n_full, n_empty);
        $display("list length peaked at %0d of %0d entries", peak_len, LIST_DEPTH);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
